[sv/rbfind_pkg.sv]
// Shared constants, codes and item types for the byte ring buffer with pattern find.
package rbfind_pkg;

  // Store geometry
  localparam int DEPTH_LOG2  = 10;
  localparam int DEPTH       = 1 << DEPTH_LOG2;
  localparam int AW          = DEPTH_LOG2;
  localparam int CNT_W       = DEPTH_LOG2 + 1;

  // Search pattern geometry
  localparam int MAX_PATTERN = 8;
  localparam int PLEN_W      = 4;
  localparam int PIDX_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // Configuration port
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 64;
  localparam logic REG_PATTERN_BYTES = 1'b0;
  localparam logic REG_PATTERN_LEN   = 1'b1;

  // Operation codes carried in the kind field
  typedef enum logic [2:0] {
    KIND_APPEND  = 3'd0,
    KIND_PEEK    = 3'd1,
    KIND_DISCARD = 3'd2,
    KIND_FIND    = 3'd3,
    KIND_CLEAR   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [10:0] block_len;
    logic        block_first;
    logic [9:0]  read_offset;
    logic [10:0] discard_count;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        found;
    logic [9:0]  match_position;
    logic [10:0] bytes_stored;
    logic [10:0] free_space;
  } out_item_t;

endpackage

[sv/byte_ring_buffer_with_pattern_find.sv]
// Byte ring buffer with block append, peek, discard, clear and pattern search.
//
// A circular store of 1024 bytes in one synchronous RAM (one write, one read port,
// registered read). Append, discard, clear and unknown kinds finish in the cycle the
// item is taken, so such items can follow one per clock unless a result stalls. Peek
// does the RAM read, then the result. Find finishes in the cycle it is taken if the
// fill is below the pattern length; else the single read port walks the stored bytes
// from the head, one per clock, through an eight-byte window, and stops at the first
// match. A stalled result is parked and item_stall stays high until it moves. The
// user must write pattern registers over the APB port only while the block is idle;
// the block does not enforce it. pattern_len 0 acts as 1, above 8 as 8.
module byte_ring_buffer_with_pattern_find (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              item_valid,
  output logic                              item_stall,
  input  rbfind_pkg::in_item_t              item,
  // result items
  output logic                              result_valid,
  input  logic                              result_stall,
  output rbfind_pkg::out_item_t             result,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rbfind_pkg::PADDR_W-1:0]    paddr,
  input  logic [rbfind_pkg::PDATA_W-1:0]    pwdata,
  output logic [rbfind_pkg::PDATA_W-1:0]    prdata,
  output logic                              pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PEEK,
    S_FIND,
    S_DELIVER
  } state_t;

  localparam int AW    = rbfind_pkg::AW;
  localparam int CNT_W = rbfind_pkg::CNT_W;
  localparam int MAXP  = rbfind_pkg::MAX_PATTERN;

  // Byte store
  logic [7:0] mem [rbfind_pkg::DEPTH];
  logic [7:0] rd_data;
  logic       mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_wdata;

  // Control state
  state_t     state, state_next;
  logic [AW-1:0]    head, head_next;
  logic [AW-1:0]    tail, tail_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic             block_rejected, block_rejected_next;
  logic             peek_ok, peek_ok_next;
  logic [CNT_W-1:0] scan_cnt, scan_cnt_next;
  logic             data_ok, data_ok_next;
  logic [AW-1:0]    data_off, data_off_next;
  logic [7:0]       window [MAXP];

  // Configuration registers
  logic [63:0]                   pattern_bytes;
  logic [rbfind_pkg::PLEN_W-1:0] pattern_len;
  logic [rbfind_pkg::PLEN_W-1:0] n_eff;

  // Result path
  rbfind_pkg::out_item_t res;
  rbfind_pkg::out_item_t hold;
  logic                  done;
  logic                  out_free;
  logic                  accept;
  logic                  hit;
  logic [7:0]            cand [MAXP];
  logic [CNT_W-1:0]      drop;
  logic                  rej_now;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign pready     = 1'b1;

  // Read back configuration
  always_comb begin
    case (paddr[rbfind_pkg::PADDR_W-1])
      rbfind_pkg::REG_PATTERN_LEN: prdata = rbfind_pkg::PDATA_W'(pattern_len);
      default:                     prdata = pattern_bytes;
    endcase
  end

  // Clamp the pattern length to 1..MAX_PATTERN
  always_comb begin
    if (pattern_len == '0) begin
      n_eff = rbfind_pkg::PLEN_W'(1);
    end else if (32'(pattern_len) > MAXP) begin
      n_eff = rbfind_pkg::PLEN_W'(MAXP);
    end else begin
      n_eff = pattern_len;
    end
  end

  // Compare the window (newest byte first) against the pattern
  always_comb begin
    logic [rbfind_pkg::PIDX_W-1:0] idx;
    idx = '0;
    cand[0] = rd_data;
    for (int j = 1; j < MAXP; j++) begin
      cand[j] = window[j-1];
    end
    hit = (32'(data_off) + 1 >= 32'(n_eff));
    for (int j = 0; j < MAXP; j++) begin
      idx = rbfind_pkg::PIDX_W'(32'(n_eff) - 1 - j);
      if (j < 32'(n_eff) && cand[idx] != pattern_bytes[8*j +: 8]) begin
        hit = 1'b0;
      end
    end
  end

  // Next state, RAM access and result of the current step
  always_comb begin
    state_next          = state;
    head_next           = head;
    tail_next           = tail;
    fill_next           = fill;
    block_rejected_next = block_rejected;
    peek_ok_next        = peek_ok;
    scan_cnt_next       = scan_cnt;
    data_ok_next        = 1'b0;
    data_off_next       = data_off;
    mem_we              = 1'b0;
    mem_waddr           = tail;
    mem_wdata           = item.data_byte;
    mem_raddr           = head;
    done                = 1'b0;
    rej_now             = block_rejected;
    drop                = '0;
    res                 = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item.kind)
            rbfind_pkg::KIND_APPEND: begin
              // decide the whole block on its first byte
              if (item.block_first) begin
                rej_now = (32'(item.block_len) > rbfind_pkg::DEPTH - 32'(fill));
              end
              block_rejected_next = rej_now;
              if (!rej_now && 32'(fill) < rbfind_pkg::DEPTH) begin
                mem_we       = 1'b1;
                tail_next    = tail + AW'(1);
                fill_next    = fill + CNT_W'(1);
                res.accepted = 1'b1;
              end
              done = 1'b1;
            end
            rbfind_pkg::KIND_PEEK: begin
              mem_raddr    = AW'(32'(head) + 32'(item.read_offset));
              peek_ok_next = (32'(item.read_offset) < 32'(fill));
              state_next   = S_PEEK;
            end
            rbfind_pkg::KIND_DISCARD: begin
              if (32'(item.discard_count) > 32'(fill)) begin
                drop = fill;
              end else begin
                drop = CNT_W'(item.discard_count);
              end
              head_next = AW'(32'(head) + 32'(drop));
              fill_next = fill - drop;
              done      = 1'b1;
            end
            rbfind_pkg::KIND_FIND: begin
              if (32'(fill) < 32'(n_eff)) begin
                done = 1'b1;
              end else begin
                // issue the read of the head byte and start the walk
                mem_raddr     = head;
                scan_cnt_next = CNT_W'(1);
                data_ok_next  = 1'b1;
                data_off_next = '0;
                state_next    = S_FIND;
              end
            end
            rbfind_pkg::KIND_CLEAR: begin
              head_next           = '0;
              tail_next           = '0;
              fill_next           = '0;
              block_rejected_next = 1'b0;
              done                = 1'b1;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_PEEK: begin
        res.read_valid = peek_ok;
        res.read_byte  = peek_ok ? rd_data : 8'h00;
        done           = 1'b1;
      end
      S_FIND: begin
        // keep one read in flight ahead of the compare
        if (scan_cnt < fill) begin
          mem_raddr     = AW'(32'(head) + 32'(scan_cnt));
          scan_cnt_next = scan_cnt + CNT_W'(1);
          data_ok_next  = 1'b1;
          data_off_next = AW'(scan_cnt);
        end
        if (data_ok) begin
          if (hit) begin
            res.found          = 1'b1;
            res.match_position = 10'(32'(data_off) + 1 - 32'(n_eff));
            done               = 1'b1;
          end else if (32'(data_off) + 1 == 32'(fill)) begin
            done = 1'b1;
          end
        end
      end
      S_DELIVER: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res.bytes_stored = 11'(fill_next);
    res.free_space   = 11'(rbfind_pkg::DEPTH - 32'(fill_next));

    if (done) begin
      state_next = out_free ? S_IDLE : S_DELIVER;
    end
  end

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Shift fetched bytes into the search window
  always_ff @(posedge clk) begin
    if (data_ok) begin
      window[0] <= rd_data;
      for (int j = 1; j < MAXP; j++) begin
        window[j] <= window[j-1];
      end
    end
  end

  // Hold state, configuration and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      head           <= '0;
      tail           <= '0;
      fill           <= '0;
      block_rejected <= 1'b0;
      data_ok        <= 1'b0;
      result_valid   <= 1'b0;
      pattern_bytes  <= '0;
      pattern_len    <= rbfind_pkg::PLEN_W'(1);
    end else begin
      state          <= state_next;
      head           <= head_next;
      tail           <= tail_next;
      fill           <= fill_next;
      block_rejected <= block_rejected_next;
      data_ok        <= data_ok_next;

      // take configuration writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[rbfind_pkg::PADDR_W-1])
          rbfind_pkg::REG_PATTERN_LEN: pattern_len   <= pwdata[rbfind_pkg::PLEN_W-1:0];
          default:                     pattern_bytes <= pwdata;
        endcase
      end

      // move a finished item into the output register or drop the taken one
      if (done && out_free) begin
        result_valid <= 1'b1;
      end else if (state == S_DELIVER && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    peek_ok  <= peek_ok_next;
    scan_cnt <= scan_cnt_next;
    data_off <= data_off_next;
    if (done && out_free) begin
      result <= res;
    end else if (state == S_DELIVER && out_free) begin
      result <= hold;
    end
    if (done && !out_free) begin
      hold <= res;
    end
  end

endmodule

[sv/rbfind_checker.sv]
// Port-level checks for the byte ring buffer with pattern find, bound to the top level.
module rbfind_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           result_valid,
  input logic                           result_stall,
  input rbfind_pkg::out_item_t          result
);

  // Fill and free space always add up to the store size
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (32'(result.bytes_stored) + 32'(result.free_space) == rbfind_pkg::DEPTH))
    else $error("fill plus free space differs from store size");

  // A stored byte leaves the buffer non-empty
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.accepted) |-> (result.bytes_stored != '0))
    else $error("append reported stored with an empty buffer");

  // A miss reports position zero, a peek outside the fill reports byte zero
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.found) |-> (result.match_position == '0))
    else $error("match position set without a match");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.read_valid) |-> (result.read_byte == '0))
    else $error("peek byte set outside the fill");

  // A stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> result_valid)
    else $error("result withdrawn while stalled");

endmodule

bind byte_ring_buffer_with_pattern_find rbfind_checker u_rbfind_checker (.*);

[bench/ring_buffer_checker.sv]
// Result checker for the byte ring buffer: tracks its contents, predicts each result, compares.
module ring_buffer_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  input  logic                           item_stall,
  input  rbfind_pkg::in_item_t           item,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  rbfind_pkg::out_item_t          result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [rbfind_pkg::PADDR_W-1:0] paddr,
  input  logic [rbfind_pkg::PDATA_W-1:0] pwdata,
  output int                             fail_count,
  output int                             awaited,
  output logic [rbfind_pkg::CNT_W-1:0]   fill_level
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the buffer and its pattern registers
  bit [7:0]                   ring_mem [rbfind_pkg::DEPTH];
  bit [rbfind_pkg::AW-1:0]     head_ptr;
  bit [rbfind_pkg::AW-1:0]     tail_ptr;
  bit [rbfind_pkg::CNT_W-1:0]  fill;
  bit                          drop_block;
  bit [63:0]                   pattern;
  bit [rbfind_pkg::PLEN_W-1:0] pattern_len;
  rbfind_pkg::out_item_t       awaited_status[$];

  initial fail_count = 0;

  task automatic flag_error(string msg);
    if (fail_count < 100) $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [10:0] got, logic [10:0] want);
    if (got !== want) flag_error($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // First offset from the head where the active pattern starts
  function automatic bit seek_pattern(output int pos);
    int  n;
    bit  hit;
    n = (pattern_len == 0) ? 1 :
        (pattern_len > rbfind_pkg::MAX_PATTERN) ? rbfind_pkg::MAX_PATTERN : pattern_len;
    pos = 0;
    for (int i = 0; i + n <= fill; i++) begin
      hit = 1'b1;
      for (int j = 0; j < n; j++)
        if (ring_mem[(head_ptr + i + j) % rbfind_pkg::DEPTH] != pattern[8*j +: 8]) hit = 1'b0;
      if (hit) begin
        pos = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Perform one operation on the shadow buffer and return the status it reports
  function automatic rbfind_pkg::out_item_t apply_op(rbfind_pkg::in_item_t op);
    rbfind_pkg::out_item_t      res;
    int                         pos;
    bit [rbfind_pkg::CNT_W-1:0] cut;
    res = '0;
    case (op.kind)
      rbfind_pkg::KIND_APPEND: begin
        // the free-space check happens on the first byte of a block only
        if (op.block_first) drop_block = (op.block_len > rbfind_pkg::DEPTH - fill);
        if (!drop_block && fill < rbfind_pkg::DEPTH) begin
          ring_mem[tail_ptr] = op.data_byte;
          tail_ptr++;
          fill++;
          res.accepted = 1'b1;
        end
      end
      rbfind_pkg::KIND_PEEK: begin
        if (op.read_offset < fill) begin
          res.read_valid = 1'b1;
          res.read_byte  = ring_mem[(head_ptr + op.read_offset) % rbfind_pkg::DEPTH];
        end
      end
      rbfind_pkg::KIND_DISCARD: begin
        cut = (op.discard_count > fill) ? fill : op.discard_count;
        head_ptr = (head_ptr + cut) % rbfind_pkg::DEPTH;
        fill -= cut;
      end
      rbfind_pkg::KIND_FIND: begin
        if (seek_pattern(pos)) begin
          res.found          = 1'b1;
          res.match_position = 10'(pos);
        end
      end
      rbfind_pkg::KIND_CLEAR: begin
        head_ptr   = '0;
        tail_ptr   = '0;
        fill       = '0;
        drop_block = 1'b0;
      end
      default: ;
    endcase
    res.bytes_stored = fill;
    res.free_space   = 11'(rbfind_pkg::DEPTH - fill);
    return res;
  endfunction

  // Track register writes, predict accepted items, compare delivered results
  always @(posedge clk) begin
    rbfind_pkg::out_item_t want;
    if (rst) begin
      head_ptr    = '0;
      tail_ptr    = '0;
      fill        = '0;
      drop_block  = 1'b0;
      pattern     = '0;
      pattern_len = rbfind_pkg::PLEN_W'(1);
      awaited_status.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          {rbfind_pkg::REG_PATTERN_BYTES, 3'b000}: pattern     = pwdata;
          {rbfind_pkg::REG_PATTERN_LEN, 3'b000}:   pattern_len = pwdata[rbfind_pkg::PLEN_W-1:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) awaited_status.push_back(apply_op(item));
      if (result_valid && !result_stall) begin
        if (awaited_status.size() == 0) begin
          flag_error("result delivered with no item outstanding");
        end else begin
          want = awaited_status.pop_front();
          check_field("accepted", result.accepted, want.accepted);
          check_field("read_byte", result.read_byte, want.read_byte);
          check_field("read_valid", result.read_valid, want.read_valid);
          check_field("found", result.found, want.found);
          check_field("match_position", result.match_position, want.match_position);
          check_field("bytes_stored", result.bytes_stored, want.bytes_stored);
          check_field("free_space", result.free_space, want.free_space);
        end
      end
    end
    awaited    <= awaited_status.size();
    fill_level <= fill;
  end

endmodule

[bench/testbench.sv]
// Stimulus and verdict for the byte ring buffer with pattern find.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] UNKNOWN_KIND_LO = rbfind_pkg::KIND_CLEAR + 3'd1;
  localparam logic [2:0] UNKNOWN_KIND_HI = 3'd7;

  logic                             clk;
  logic                             rst;
  logic                             item_valid;
  logic                             item_stall;
  rbfind_pkg::in_item_t             item;
  logic                             result_valid;
  logic                             result_stall;
  rbfind_pkg::out_item_t            result;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [rbfind_pkg::PADDR_W-1:0]   paddr;
  logic [rbfind_pkg::PDATA_W-1:0]   pwdata;
  logic [rbfind_pkg::PDATA_W-1:0]   prdata;
  logic                             pready;
  int                               fail_count;
  int                               awaited;
  logic [rbfind_pkg::CNT_W-1:0]     fill_level;

  // Stimulus state: active pattern, run of pattern bytes being emitted, traffic mode
  logic [63:0] cur_pattern;
  int          eff_len;
  int          run_pos;
  int          run_end;
  bit          steady;
  bit          filling;

  byte_ring_buffer_with_pattern_find u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  ring_buffer_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .awaited      (awaited),
    .fill_level   (fill_level)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop for a hung run
  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

  // Gap length: mostly none, often short, rarely long
  function automatic int idle_span(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pack one item; each field keeps the low bits of its argument
  function automatic rbfind_pkg::in_item_t make_op(logic [31:0] kind, logic [31:0] data,
                                                   logic [31:0] blen, logic [31:0] first,
                                                   logic [31:0] roff, logic [31:0] dcnt);
    rbfind_pkg::in_item_t op;
    op.kind          = 3'(kind);
    op.data_byte     = 8'(data);
    op.block_len     = 11'(blen);
    op.block_first   = 1'(first);
    op.read_offset   = 10'(roff);
    op.discard_count = 11'(dcnt);
    return op;
  endfunction

  // Append data: partial or whole pattern runs, pattern-alphabet bytes, or noise
  function automatic logic [7:0] next_data();
    int r;
    if (run_pos < run_end) begin
      run_pos++;
      return cur_pattern[8*(run_pos-1) +: 8];
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      run_end = ($urandom_range(0, 3) == 0) ? $urandom_range(1, eff_len) : eff_len;
      run_pos = 1;
      return cur_pattern[7:0];
    end
    if (r < 50) return cur_pattern[8*$urandom_range(0, 7) +: 8];
    return 8'($urandom);
  endfunction

  // Present one item after an optional gap and hold it until taken
  task automatic offer(rbfind_pkg::in_item_t op);
    int gap;
    gap = idle_span(steady);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= op;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait until every result is back
  task automatic settle();
    item_valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
  endtask

  task automatic write_reg(logic [rbfind_pkg::PADDR_W-1:0] addr,
                           logic [rbfind_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_pattern(logic [63:0] pat, logic [3:0] len);
    write_reg({rbfind_pkg::REG_PATTERN_BYTES, 3'b000}, pat);
    write_reg({rbfind_pkg::REG_PATTERN_LEN, 3'b000}, rbfind_pkg::PDATA_W'(len));
    cur_pattern = pat;
    eff_len     = (len == 0) ? 1 :
                  (len > rbfind_pkg::MAX_PATTERN) ? rbfind_pkg::MAX_PATTERN : len;
    run_pos     = 0;
    run_end     = 0;
  endtask

  task automatic append_block(int len, logic [10:0] declared, logic lead);
    for (int k = 0; k < len; k++)
      offer(make_op(rbfind_pkg::KIND_APPEND, next_data(), (k == 0) ? declared : 11'($urandom),
                    (k == 0) ? lead : 1'b0, $urandom, $urandom));
  endtask

  // Random traffic: fill toward full with blocks, then drain with discards
  task automatic random_ops(int count);
    int          done;
    int          r;
    int          len;
    int          fl;
    logic [10:0] declared;
    logic [9:0]  off;
    logic [10:0] cnt;
    done = 0;
    while (done < count) begin
      fl = fill_level;
      if (fl < 64) filling = 1'b1;
      else if (fl > 900) filling = 1'b0;
      r = $urandom_range(0, 99);
      if (r < (filling ? 60 : 30)) begin
        if (filling && fl > 700 && $urandom_range(0, 3) == 0) begin
          // overrun the free space with a declared length that fits
          len      = rbfind_pkg::DEPTH - fl + $urandom_range(1, 20);
          declared = 11'($urandom_range(0, rbfind_pkg::DEPTH - fl));
        end else begin
          r = $urandom_range(0, 99);
          if (!filling || r < 70) len = $urandom_range(1, 16);
          else if (r < 88) len = $urandom_range(17, 100);
          else len = $urandom_range(101, 300);
          r = $urandom_range(0, 99);
          if (r < 80) declared = 11'(len);
          else if (r < 90) declared = 11'($urandom_range(0, len - 1));
          else if (r < 97) declared = 11'($urandom_range(len, rbfind_pkg::DEPTH));
          else declared = 11'($urandom);
        end
        append_block(len, declared, $urandom_range(0, 99) >= 3);
        done += len;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          if (fl > 0 && r < 25) off = 10'($urandom_range(0, fl - 1));
          else if (r < 30) off = 10'(fl + $urandom_range(0, 3));
          else off = 10'($urandom);
          offer(make_op(rbfind_pkg::KIND_PEEK, $urandom, $urandom, $urandom, off, $urandom));
        end else if (r < 65) begin
          if (filling) cnt = 11'($urandom_range(0, 4));
          else if (r < 62) cnt = 11'($urandom_range(0, 128));
          else cnt = 11'($urandom);
          offer(make_op(rbfind_pkg::KIND_DISCARD, $urandom, $urandom, $urandom, $urandom, cnt));
        end else if (r < 88 || (r >= 94 && filling)) begin
          offer(make_op(rbfind_pkg::KIND_FIND, $urandom, $urandom, $urandom, $urandom,
                        $urandom));
        end else if (r < 94) begin
          offer(make_op($urandom_range(UNKNOWN_KIND_HI, UNKNOWN_KIND_LO),
                        $urandom, $urandom, $urandom, $urandom, $urandom));
        end else begin
          offer(make_op(rbfind_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, $urandom,
                        $urandom));
        end
        done++;
      end
    end
  endtask

  // Result side: random stall runs between ready stretches, some of them long
  initial begin
    int n;
    result_stall = 1'b0;
    @(negedge clk);
    forever begin
      n = idle_span(1'b0);
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      result_stall <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 4))
        @(negedge clk);
    end
  end

  initial begin
    rst         = 1'b1;
    item_valid  = 1'b0;
    item        = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cur_pattern = '0;
    eff_len     = 1;
    run_pos     = 0;
    run_end     = 0;
    steady      = 1'b0;
    filling     = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty buffer, a known match, rejects, clamps, clear
    set_pattern(64'h8877_6655_4433_2211, 4'd3);
    offer(make_op(rbfind_pkg::KIND_PEEK, 8'h00, 11'd0, 1'b0, 10'd0, 11'd0));
    offer(make_op(rbfind_pkg::KIND_FIND, 8'h00, 11'd0, 1'b0, 10'd0, 11'd0));
    offer(make_op(rbfind_pkg::KIND_DISCARD, 8'h00, 11'd0, 1'b0, 10'd0, 11'd5));
    // continuation byte straight after reset is taken
    offer(make_op(rbfind_pkg::KIND_APPEND, 8'h00, 11'd0, 1'b0, 10'd0, 11'd0));
    offer(make_op(rbfind_pkg::KIND_APPEND, 8'hFF, 11'd4, 1'b1, 10'd0, 11'd0));
    offer(make_op(rbfind_pkg::KIND_APPEND, 8'h11, 11'd0, 1'b0, 10'd0, 11'd0));
    offer(make_op(rbfind_pkg::KIND_APPEND, 8'h22, 11'd0, 1'b0, 10'd0, 11'd0));
    offer(make_op(rbfind_pkg::KIND_APPEND, 8'h33, 11'd0, 1'b0, 10'd0, 11'd0));
    offer(make_op(rbfind_pkg::KIND_FIND, 8'h00, 11'd0, 1'b0, 10'd0, 11'd0));
    offer(make_op(rbfind_pkg::KIND_PEEK, 8'h00, 11'd0, 1'b0, 10'd4, 11'd0));
    offer(make_op(rbfind_pkg::KIND_PEEK, 8'h00, 11'd0, 1'b0, 10'd5, 11'd0));
    offer(make_op(rbfind_pkg::KIND_PEEK, 8'h00, 11'd0, 1'b0, 10'd1023, 11'd0));
    // block longer than the free space: both bytes dropped
    offer(make_op(rbfind_pkg::KIND_APPEND, 8'hAA, 11'd1024, 1'b1, 10'd0, 11'd0));
    offer(make_op(rbfind_pkg::KIND_APPEND, 8'hBB, 11'd0, 1'b0, 10'd0, 11'd0));
    offer(make_op(rbfind_pkg::KIND_APPEND, 8'h44, 11'd0, 1'b1, 10'd0, 11'd0));
    offer(make_op(UNKNOWN_KIND_HI, 8'h00, 11'd0, 1'b0, 10'd0, 11'd0));
    offer(make_op(rbfind_pkg::KIND_DISCARD, 8'h00, 11'd0, 1'b0, 10'd0, 11'd2047));
    offer(make_op(rbfind_pkg::KIND_FIND, 8'h00, 11'd0, 1'b0, 10'd0, 11'd0));
    offer(make_op(rbfind_pkg::KIND_APPEND, 8'h77, 11'd2047, 1'b1, 10'd0, 11'd0));
    // clear forgets the rejected block
    offer(make_op(rbfind_pkg::KIND_CLEAR, 8'h00, 11'd0, 1'b0, 10'd0, 11'd0));
    offer(make_op(rbfind_pkg::KIND_APPEND, 8'h55, 11'd0, 1'b0, 10'd0, 11'd0));
    offer(make_op(rbfind_pkg::KIND_CLEAR, 8'h00, 11'd0, 1'b0, 10'd0, 11'd0));
    offer(make_op(rbfind_pkg::KIND_APPEND, 8'h66, 11'd1024, 1'b1, 10'd0, 11'd0));
    offer(make_op(rbfind_pkg::KIND_DISCARD, 8'h00, 11'd0, 1'b0, 10'd0, 11'd1));
    settle();

    // Random phases, each under its own pattern setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_pattern({$urandom, $urandom}, 4'd1);
        1: set_pattern({$urandom, $urandom}, 4'd8);
        2: set_pattern(64'h0, 4'd0);
        3: set_pattern(64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        4: set_pattern({$urandom, $urandom}, 4'd2);
        default: set_pattern({$urandom, $urandom}, 4'd4);
      endcase
      steady = (ph == 4);
      random_ops(300);
      settle();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && awaited == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[byte_ring_buffer_with_pattern_find.f]
sv/rbfind_pkg.sv
sv/byte_ring_buffer_with_pattern_find.sv
sv/rbfind_checker.sv
bench/ring_buffer_checker.sv
bench/testbench.sv
